>>> hw/rtl/lprd_pkg.sv
// Shared types and constants for the length-prefixed request deframer.
// Holds the input and result item structs, result codes and size limits.
// No dependencies.
`default_nettype none

package lprd_pkg;

    localparam int MAX_MESSAGE_BYTES = 4096;
    // Register, counter and limit width: holds values up to 8191.
    localparam int LIM_W      = 13;
    localparam int FIELD_W    = 32;
    localparam int ARG_IDX_W  = 10;
    localparam int HDR_BYTES  = 4;

    // A cap above what the register can hold never binds.
    localparam logic [LIM_W-1:0] LIMIT_CAP =
        (MAX_MESSAGE_BYTES > 8191) ? LIM_W'(8191) : LIM_W'(MAX_MESSAGE_BYTES);
    localparam logic [LIM_W-1:0] MAX_MSG_RESET =
        (MAX_MESSAGE_BYTES > 8191) ? LIM_W'(8191) : LIM_W'(MAX_MESSAGE_BYTES);

    // First three bytes of argument 0, first byte lowest.
    localparam logic [23:0] WORD_GET = 24'h746567;
    localparam logic [23:0] WORD_SET = 24'h746573;
    localparam logic [23:0] WORD_DEL = 24'h6C6564;

    typedef enum logic [1:0] {
        KIND_ARG_BYTE  = 2'd0,
        KIND_EMPTY_ARG = 2'd1,
        KIND_REQ_END   = 2'd2,
        KIND_ERROR     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CMD_UNKNOWN = 2'd0,
        CMD_GET     = 2'd1,
        CMD_SET     = 2'd2,
        CMD_DEL     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_TOO_LONG  = 2'd1,
        ERR_MALFORMED = 2'd2
    } t_err;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       new_connection;
    } t_in_item;

    typedef struct packed {
        t_kind                  kind;
        logic [7:0]             data_byte;
        logic [ARG_IDX_W-1:0]   arg_index;
        logic                   last_of_arg;
        logic                   last_of_request;
        t_cmd                   command;
        t_err                   error_code;
    } t_out_item;

endpackage

`default_nettype wire

>>> hw/rtl/length_prefixed_request_deframer_unit.sv
// Top level of the length-prefixed request deframer: input register,
// parser core, result register and the message limit register.
// Depends on lprd_pkg and lprd_core.
//
//   channel  direction  handshake                   payload
//   in       sink       i_in_valid  / o_in_stall    i_in_item  (t_in_item)
//   out      source     o_out_valid / i_out_stall   o_out_item (t_out_item)
//   cfg      sink       i_cfg_valid / o_cfg_ready   i_cfg_data (13 bits)
//
// One byte per cycle sustained while the output is not stalled; a result passes
// through the input register, then the result register, to the output.
// The parser state loop updates on each fire, so the core never stalls.
// i_rst_n is synchronous, active low; it clears the parser and restores the
// limit register. A stall on a held result backs up into o_in_stall in the
// same cycle once the input register is full.
`default_nettype none

module length_prefixed_request_deframer_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire lprd_pkg::t_in_item            i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output lprd_pkg::t_out_item                o_out_item,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lprd_pkg::LIM_W-1:0]    i_cfg_data
);

    logic                           r_in_valid;
    lprd_pkg::t_in_item             r_in_item;
    logic                           r_out_valid;
    lprd_pkg::t_out_item            r_out_item;
    logic [lprd_pkg::LIM_W-1:0]     r_max_msg;

    logic                           adv;
    logic                           fire;
    logic [lprd_pkg::LIM_W-1:0]     limit;
    logic                           has_result;
    lprd_pkg::t_out_item            result;

    assign limit = (r_max_msg > lprd_pkg::LIMIT_CAP) ? lprd_pkg::LIMIT_CAP : r_max_msg;

    // The core step moves forward whenever the result register can load.
    assign adv         = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && adv;
    assign o_in_stall  = r_in_valid && !adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    lprd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (r_in_item),
        .i_limit      (limit),
        .o_has_result (has_result),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_msg   <= lprd_pkg::MAX_MSG_RESET;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid && has_result;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_msg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (fire && has_result) begin
            r_out_item <= result;
        end
    end

    a_err_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind == lprd_pkg::KIND_ERROR)
            |-> (o_out_item.error_code != lprd_pkg::ERR_NONE))
        else $error("error item without error code");

    a_end_not_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.last_of_request)
            |-> (o_out_item.kind != lprd_pkg::KIND_ERROR))
        else $error("request end flagged on an error item");

    a_stall_only_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output free");

    a_limit_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_max_msg == lprd_pkg::MAX_MSG_RESET && !o_out_valid))
        else $error("reset did not restore limit and output");

endmodule

`default_nettype wire

>>> hw/rtl/lprd_core.sv
// Parser state and per-byte step logic of the request deframer.
// One item is decoded per fire; the result comes out combinationally.
// Depends on lprd_pkg.
`default_nettype none

module lprd_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire lprd_pkg::t_in_item            i_item,
    input  wire logic [lprd_pkg::LIM_W-1:0]    i_limit,
    output logic                               o_has_result,
    output lprd_pkg::t_out_item                o_result
);

    typedef enum logic [2:0] {
        PH_LEN    = 3'd0,
        PH_COUNT  = 3'd1,
        PH_ARGLEN = 3'd2,
        PH_DATA   = 3'd3,
        PH_DROP   = 3'd4
    } t_phase;

    localparam int LW = lprd_pkg::LIM_W;
    localparam int FW = lprd_pkg::FIELD_W;
    localparam int AW = lprd_pkg::ARG_IDX_W;

    t_phase          r_phase, n_phase, c_phase;
    logic [1:0]      r_hbc, n_hbc, c_hbc;
    logic [FW-1:0]   r_shift, n_shift, c_shift;
    logic [LW-1:0]   r_pay, n_pay, c_pay;
    logic [LW-1:0]   r_args, n_args, c_args;
    logic [LW-1:0]   r_total, n_total, c_total;
    logic [LW-1:0]   r_abr, n_abr, c_abr;
    logic [AW-1:0]   r_cur, n_cur, c_cur;
    logic [23:0]     r_faw, n_faw, c_faw;
    logic [LW-1:0]   r_fal, n_fal, c_fal;

    logic [LW-1:0]   pay_dec, abr_dec, args_dec, pos;
    logic [FW-1:0]   field;
    logic            arg_end;
    lprd_pkg::t_kind end_kind;
    logic [7:0]      end_data;
    logic [7:0]      b;

    function automatic lprd_pkg::t_cmd cmd_of(input logic [LW-1:0] fal,
                                              input logic [LW-1:0] total,
                                              input logic [23:0]   word);
        lprd_pkg::t_cmd c;
        c = lprd_pkg::CMD_UNKNOWN;
        if (fal == LW'(3)) begin
            if (total == LW'(2) && word == lprd_pkg::WORD_GET) begin
                c = lprd_pkg::CMD_GET;
            end else if (total == LW'(3) && word == lprd_pkg::WORD_SET) begin
                c = lprd_pkg::CMD_SET;
            end else if (total == LW'(2) && word == lprd_pkg::WORD_DEL) begin
                c = lprd_pkg::CMD_DEL;
            end
        end
        return c;
    endfunction

    always_comb begin
        b = i_item.byte_value;
        // A new connection clears the parser before the byte is taken.
        if (i_item.new_connection) begin
            c_phase = PH_LEN;
            c_hbc   = '0;
            c_shift = '0;
            c_pay   = '0;
            c_args  = '0;
            c_total = '0;
            c_abr   = '0;
            c_cur   = '0;
            c_faw   = '0;
            c_fal   = '0;
        end else begin
            c_phase = r_phase;
            c_hbc   = r_hbc;
            c_shift = r_shift;
            c_pay   = r_pay;
            c_args  = r_args;
            c_total = r_total;
            c_abr   = r_abr;
            c_cur   = r_cur;
            c_faw   = r_faw;
            c_fal   = r_fal;
        end

        n_phase = c_phase;
        n_hbc   = c_hbc;
        n_shift = c_shift;
        n_pay   = c_pay;
        n_args  = c_args;
        n_total = c_total;
        n_abr   = c_abr;
        n_cur   = c_cur;
        n_faw   = c_faw;
        n_fal   = c_fal;

        pay_dec  = c_pay - LW'(c_pay != '0);
        abr_dec  = c_abr - LW'(c_abr != '0);
        args_dec = c_args - LW'(c_args != '0);
        pos      = c_fal - c_abr;
        field    = (c_hbc == 2'd0) ? FW'(b) : (c_shift | (FW'(b) << {c_hbc, 3'b000}));

        arg_end  = 1'b0;
        end_kind = lprd_pkg::KIND_ARG_BYTE;
        end_data = '0;

        o_has_result = 1'b0;
        o_result     = '0;

        unique case (c_phase)
            PH_DROP: begin
            end
            PH_DATA: begin
                n_pay = pay_dec;
                if (c_args == c_total && pos < LW'(3)) begin
                    n_faw = c_faw | (24'(b) << {pos[1:0], 3'b000});
                end
                n_abr = abr_dec;
                if (abr_dec == '0) begin
                    arg_end  = 1'b1;
                    end_kind = lprd_pkg::KIND_ARG_BYTE;
                    end_data = b;
                end else begin
                    o_has_result       = 1'b1;
                    o_result.kind      = lprd_pkg::KIND_ARG_BYTE;
                    o_result.data_byte = b;
                    o_result.arg_index = c_cur;
                end
            end
            default: begin
                // Header phases gather a 4-byte little-endian field.
                if (c_phase != PH_LEN) begin
                    n_pay = pay_dec;
                end
                n_shift = field;
                if (c_hbc != 2'd3) begin
                    n_hbc = c_hbc + 2'd1;
                end else begin
                    n_hbc = '0;
                    priority case (c_phase)
                        PH_LEN: begin
                            if (field > FW'(i_limit)) begin
                                o_has_result        = 1'b1;
                                o_result.kind       = lprd_pkg::KIND_ERROR;
                                o_result.error_code = lprd_pkg::ERR_TOO_LONG;
                                n_phase             = PH_DROP;
                            end else if (field < FW'(lprd_pkg::HDR_BYTES)) begin
                                o_has_result        = 1'b1;
                                o_result.kind       = lprd_pkg::KIND_ERROR;
                                o_result.error_code = lprd_pkg::ERR_MALFORMED;
                                n_phase             = PH_DROP;
                            end else begin
                                n_pay   = field[LW-1:0];
                                n_phase = PH_COUNT;
                            end
                        end
                        PH_COUNT: begin
                            if (field > FW'(i_limit)) begin
                                o_has_result        = 1'b1;
                                o_result.kind       = lprd_pkg::KIND_ERROR;
                                o_result.error_code = lprd_pkg::ERR_MALFORMED;
                                n_phase             = PH_DROP;
                            end else begin
                                n_total = field[LW-1:0];
                                n_args  = field[LW-1:0];
                                n_cur   = '0;
                                n_faw   = '0;
                                n_fal   = '0;
                                if (field == '0) begin
                                    o_has_result = 1'b1;
                                    if (pay_dec != '0) begin
                                        o_result.kind       = lprd_pkg::KIND_ERROR;
                                        o_result.error_code = lprd_pkg::ERR_MALFORMED;
                                        n_phase             = PH_DROP;
                                    end else begin
                                        o_result.kind            = lprd_pkg::KIND_REQ_END;
                                        o_result.last_of_request = 1'b1;
                                        n_phase                  = PH_LEN;
                                    end
                                end else if (pay_dec < LW'(lprd_pkg::HDR_BYTES)) begin
                                    o_has_result        = 1'b1;
                                    o_result.kind       = lprd_pkg::KIND_ERROR;
                                    o_result.error_code = lprd_pkg::ERR_MALFORMED;
                                    n_phase             = PH_DROP;
                                end else begin
                                    n_phase = PH_ARGLEN;
                                end
                            end
                        end
                        default: begin
                            // Final argument must end at the payload end; others
                            // must leave room for the next length header.
                            if ((c_args <= LW'(1) && field != FW'(pay_dec)) ||
                                (c_args > LW'(1) &&
                                 ({1'b0, field} + (FW+1)'(lprd_pkg::HDR_BYTES)) >
                                 (FW+1)'(pay_dec))) begin
                                o_has_result        = 1'b1;
                                o_result.kind       = lprd_pkg::KIND_ERROR;
                                o_result.error_code = lprd_pkg::ERR_MALFORMED;
                                n_phase             = PH_DROP;
                            end else begin
                                n_abr = field[LW-1:0];
                                if (c_args == c_total) begin
                                    n_fal = field[LW-1:0];
                                    n_faw = '0;
                                end
                                if (field == '0) begin
                                    arg_end  = 1'b1;
                                    end_kind = lprd_pkg::KIND_EMPTY_ARG;
                                end else begin
                                    n_phase = PH_DATA;
                                end
                            end
                        end
                    endcase
                end
            end
        endcase

        if (arg_end) begin
            n_args                = args_dec;
            n_cur                 = c_cur + AW'(1);
            n_hbc                 = '0;
            o_has_result          = 1'b1;
            o_result.kind         = end_kind;
            o_result.data_byte    = end_data;
            o_result.arg_index    = c_cur;
            o_result.last_of_arg  = 1'b1;
            if (args_dec == '0) begin
                o_result.last_of_request = 1'b1;
                o_result.command         = cmd_of(n_fal, c_total, n_faw);
                n_phase                  = PH_LEN;
            end else begin
                n_phase = PH_ARGLEN;
            end
        end

        // Hold the drop phase with its header count cleared.
        if (n_phase == PH_DROP) begin
            n_hbc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;
            r_hbc   <= '0;
            r_shift <= '0;
            r_pay   <= '0;
            r_args  <= '0;
            r_total <= '0;
            r_abr   <= '0;
            r_cur   <= '0;
            r_faw   <= '0;
            r_fal   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_hbc   <= n_hbc;
            r_shift <= n_shift;
            r_pay   <= n_pay;
            r_args  <= n_args;
            r_total <= n_total;
            r_abr   <= n_abr;
            r_cur   <= n_cur;
            r_faw   <= n_faw;
            r_fal   <= n_fal;
        end
    end

endmodule

`default_nettype wire

>>> tb/length_prefixed_request_deframer_checker.sv
// Checker for the length-prefixed request deframer: watches the input, result and
// limit channels, predicts every result from the accepted bytes and compares them.
// Depends on lprd_pkg.
module length_prefixed_request_deframer_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  lprd_pkg::t_in_item           i_in_item,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  lprd_pkg::t_out_item          i_out_item,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [lprd_pkg::LIM_W-1:0]   i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lprd_pkg::*;

    typedef enum logic [2:0] {
        ST_OUTER_LEN,
        ST_ARG_COUNT,
        ST_ARG_LEN,
        ST_ARG_DATA,
        ST_DROP
    } t_parse_st;

    t_parse_st          st;
    logic [1:0]         hdr_cnt;
    logic [31:0]        hdr_word;
    logic [LIM_W-1:0]   payload_left;
    logic [LIM_W-1:0]   args_left;
    logic [LIM_W-1:0]   args_total;
    logic [31:0]        arg_left;
    logic [9:0]         arg_no;
    logic [23:0]        verb_word;
    logic [31:0]        verb_len;
    logic [LIM_W-1:0]   limit_reg;

    t_out_item          parsed_q[$];
    int                 mismatches = 0;
    int                 queued = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = queued;

    function automatic void clear_parser();
        st           = ST_OUTER_LEN;
        hdr_cnt      = '0;
        hdr_word     = '0;
        payload_left = '0;
        args_left    = '0;
        args_total   = '0;
        arg_left     = '0;
        arg_no       = '0;
        verb_word    = '0;
        verb_len     = '0;
    endfunction

    function automatic t_out_item make_result(t_kind k, logic [7:0] d, logic [9:0] idx,
                                              logic loa, logic lor, t_cmd c, t_err e);
        t_out_item r;
        r.kind            = k;
        r.data_byte       = d;
        r.arg_index       = idx;
        r.last_of_arg     = loa;
        r.last_of_request = lor;
        r.command         = c;
        r.error_code      = e;
        return r;
    endfunction

    function automatic t_out_item reject(t_err e);
        st      = ST_DROP;
        hdr_cnt = '0;
        return make_result(KIND_ERROR, 8'd0, 10'd0, 1'b0, 1'b0, CMD_UNKNOWN, e);
    endfunction

    function automatic t_cmd verb_cmd();
        if (verb_len != 32'd3)
            return CMD_UNKNOWN;
        if (args_total == 2 && verb_word == WORD_GET)
            return CMD_GET;
        if (args_total == 3 && verb_word == WORD_SET)
            return CMD_SET;
        if (args_total == 2 && verb_word == WORD_DEL)
            return CMD_DEL;
        return CMD_UNKNOWN;
    endfunction

    function automatic t_out_item close_arg(t_kind k, logic [7:0] d);
        logic [9:0] idx;
        logic       lor;
        t_cmd       c;
        idx = arg_no;
        lor = 1'b0;
        c   = CMD_UNKNOWN;
        if (args_left != 0)
            args_left = args_left - 1'b1;
        arg_no  = arg_no + 1'b1;
        hdr_cnt = '0;
        if (args_left == 0) begin
            lor = 1'b1;
            c   = verb_cmd();
            st  = ST_OUTER_LEN;
        end else begin
            st = ST_ARG_LEN;
        end
        return make_result(k, d, idx, 1'b1, lor, c, ERR_NONE);
    endfunction

    // Advance the parser by one byte; returns 1 when the byte yields a result.
    function automatic bit parse_byte(input t_in_item it, output t_out_item res);
        logic [7:0]       b;
        logic [LIM_W-1:0] lim;
        logic [31:0]      f;
        logic [31:0]      pos;
        b   = it.byte_value;
        lim = (limit_reg > LIMIT_CAP) ? LIMIT_CAP : limit_reg;
        res = '0;
        if (it.new_connection)
            clear_parser();
        if (st == ST_DROP)
            return 0;

        if (st == ST_ARG_DATA) begin
            if (payload_left != 0)
                payload_left = payload_left - 1'b1;
            if (args_left == args_total) begin
                pos = verb_len - arg_left;
                if (pos < 3)
                    verb_word = verb_word | (24'(b) << (8 * pos));
            end
            if (arg_left != 0)
                arg_left = arg_left - 1;
            if (arg_left == 0)
                res = close_arg(KIND_ARG_BYTE, b);
            else
                res = make_result(KIND_ARG_BYTE, b, arg_no, 1'b0, 1'b0, CMD_UNKNOWN,
                                  ERR_NONE);
            return 1;
        end

        // gather a little-endian header word
        if (st != ST_OUTER_LEN && payload_left != 0)
            payload_left = payload_left - 1'b1;
        if (hdr_cnt == 0)
            hdr_word = {24'd0, b};
        else
            hdr_word = hdr_word | (32'(b) << (8 * hdr_cnt));
        if (hdr_cnt != 2'd3) begin
            hdr_cnt = hdr_cnt + 1'b1;
            return 0;
        end
        hdr_cnt = '0;
        f = hdr_word;

        if (st == ST_OUTER_LEN) begin
            if (f > 32'(lim)) begin
                res = reject(ERR_TOO_LONG);
                return 1;
            end
            if (f < 32'd4) begin
                res = reject(ERR_MALFORMED);
                return 1;
            end
            payload_left = f[LIM_W-1:0];
            st = ST_ARG_COUNT;
            return 0;
        end

        if (st == ST_ARG_COUNT) begin
            if (f > 32'(lim)) begin
                res = reject(ERR_MALFORMED);
                return 1;
            end
            args_total = f[LIM_W-1:0];
            args_left  = f[LIM_W-1:0];
            arg_no     = '0;
            verb_word  = '0;
            verb_len   = '0;
            if (f == 0) begin
                if (payload_left != 0) begin
                    res = reject(ERR_MALFORMED);
                    return 1;
                end
                st  = ST_OUTER_LEN;
                res = make_result(KIND_REQ_END, 8'd0, 10'd0, 1'b0, 1'b1, CMD_UNKNOWN,
                                  ERR_NONE);
                return 1;
            end
            if (payload_left < 4) begin
                res = reject(ERR_MALFORMED);
                return 1;
            end
            st = ST_ARG_LEN;
            return 0;
        end

        // argument length: the last one must end the payload exactly,
        // the others must leave room for the next length word
        if (args_left <= 1) begin
            if (f != 32'(payload_left)) begin
                res = reject(ERR_MALFORMED);
                return 1;
            end
        end else if ({1'b0, f} + 33'd4 > 33'(payload_left)) begin
            res = reject(ERR_MALFORMED);
            return 1;
        end
        arg_left = f;
        if (args_left == args_total) begin
            verb_len  = f;
            verb_word = '0;
        end
        if (f == 0) begin
            res = close_arg(KIND_EMPTY_ARG, 8'd0);
            return 1;
        end
        st = ST_ARG_DATA;
        return 0;
    endfunction

    function automatic bit field_differs(string name, logic [31:0] want, logic [31:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item got;
        t_out_item res;
        bit        bad;
        if (!i_rst_n) begin
            clear_parser();
            limit_reg = MAX_MSG_RESET;
            parsed_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out_item;
                if (parsed_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = parsed_q.pop_front();
                    bad = 0;
                    bad |= field_differs("kind", want.kind, got.kind);
                    bad |= field_differs("data_byte", want.data_byte, got.data_byte);
                    bad |= field_differs("arg_index", want.arg_index, got.arg_index);
                    bad |= field_differs("last_of_arg", want.last_of_arg, got.last_of_arg);
                    bad |= field_differs("last_of_request", want.last_of_request,
                                         got.last_of_request);
                    bad |= field_differs("command", want.command, got.command);
                    bad |= field_differs("error_code", want.error_code, got.error_code);
                    if (bad)
                        mismatches++;
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                limit_reg = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                if (parse_byte(i_in_item, res))
                    parsed_q.insert(parsed_q.size(), res);
            end
        end
        queued = parsed_q.size();
    end

endmodule

>>> tb/length_prefixed_request_deframer_unit_tb.sv
// Testbench top for length_prefixed_request_deframer_unit: builds request byte
// streams (directed cases, then random requests with corruption) and gives the verdict.
// Depends on lprd_pkg, the deframer RTL and length_prefixed_request_deframer_checker.
module length_prefixed_request_deframer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lprd_pkg::*;

    localparam int DRAIN_CYCLES = 6;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    t_in_item          in_item = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_item         out_item;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LIM_W-1:0]  cfg_data = '0;
    int                fail_count;
    int                pending;

    t_in_item          req_q[$];
    logic              next_nc = 1'b0;
    logic              tainted = 1'b0;
    logic [23:0]       verb = '0;
    int                arg_len [0:1023];
    int                eff_lim = MAX_MESSAGE_BYTES;
    int                bytes_sent = 0;
    int                burst_left = 0;
    int                stall_run = 0;

    always #2 clk = ~clk;

    length_prefixed_request_deframer_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    length_prefixed_request_deframer_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: short stalls between runs, some runs long enough to stream freely.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end else if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else if (out_stall) begin
            out_stall <= 1'b0;
            stall_run <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end else begin
            out_stall <= 1'b1;
            stall_run <= $urandom_range(0, 3);
        end
    end

    function automatic void add_byte(logic [7:0] b);
        t_in_item it;
        it.byte_value     = b;
        it.new_connection = next_nc;
        next_nc = 1'b0;
        req_q.insert(req_q.size(), it);
    endfunction

    function automatic void add_word(logic [31:0] w);
        int i;
        for (i = 0; i < 4; i++)
            add_byte(w[8*i +: 8]);
    endfunction

    function automatic void add_noise(int n);
        int i;
        for (i = 0; i < n; i++) begin
            next_nc = ($urandom_range(0, 7) == 0);
            add_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void set_nc(int k);
        t_in_item it;
        it = req_q[k];
        it.new_connection = 1'b1;
        req_q[k] = it;
    endfunction

    // Append one request from arg_len[] and verb; skew shifts the declared payload length.
    function automatic int build_request(int nargs, int skew);
        int total;
        int i;
        int j;
        total = 4;
        for (i = 0; i < nargs; i++)
            total += 4 + arg_len[i];
        add_word(32'(total + skew));
        add_word(32'(nargs));
        for (i = 0; i < nargs; i++) begin
            add_word(32'(arg_len[i]));
            for (j = 0; j < arg_len[i]; j++)
                add_byte((i == 0 && j < 3) ? verb[8*j +: 8] : 8'($urandom_range(0, 255)));
        end
        return total;
    endfunction

    // Sender: bursts of items with random gaps; valid stays high inside a burst.
    task automatic send_byte(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task automatic flush_items();
        while (req_q.size() != 0)
            send_byte(req_q.pop_front());
    endtask

    // Hold the sender until every predicted result has come out.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        eff_lim = (v > MAX_MESSAGE_BYTES) ? MAX_MESSAGE_BYTES : int'(v);
    endtask

    task automatic random_request();
        int       nargs;
        int       n;
        int       k;
        int       i;
        t_in_item it;
        case ($urandom_range(0, 3))
            0: verb = WORD_GET;
            1: verb = WORD_SET;
            2: verb = WORD_DEL;
            default: verb = 24'($urandom);
        endcase
        n = $urandom_range(0, 9);
        if (n == 0)
            nargs = 0;
        else if (n < 6)
            nargs = (verb == WORD_SET) ? 3 : 2;
        else if (n < 9)
            nargs = $urandom_range(1, 4);
        else
            nargs = $urandom_range(5, 16);
        for (i = 0; i < nargs; i++)
            arg_len[i] = ($urandom_range(0, 24) == 0) ? $urandom_range(11, 300)
                                                      : $urandom_range(0, 10);
        if (nargs > 0 && $urandom_range(0, 3) != 0)
            arg_len[0] = 3;
        // restart the connection after anything that may have left the parser dropping
        next_nc = tainted || ($urandom_range(0, 4) == 0);
        tainted = (build_request(nargs, 0) > eff_lim);
        if ($urandom_range(0, 4) == 0) begin
            tainted = 1'b1;
            n = req_q.size();
            case ($urandom_range(0, 3))
                0: begin
                    k = $urandom_range(0, (n > 16) ? 15 : n - 1);
                    it = req_q[k];
                    it.byte_value ^= 8'($urandom_range(1, 255));
                    req_q[k] = it;
                end
                1: begin
                    k = $urandom_range(1, n - 1);
                    while (req_q.size() > k)
                        req_q.delete(req_q.size() - 1);
                end
                2: add_noise($urandom_range(1, 20));
                default: set_nc($urandom_range(1, n - 1));
            endcase
        end
        flush_items();
        if ($urandom_range(0, 29) == 0)
            drain_results();
    endtask

    initial begin : stimulus
        int i;
        int p;
        int target;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        write_limit(13'd4096);

        // well-formed requests and command decoding
        next_nc = 1'b1;
        verb = WORD_GET; arg_len[0] = 3; arg_len[1] = 5;
        void'(build_request(2, 0));
        verb = WORD_SET; arg_len[1] = 4; arg_len[2] = 6;
        void'(build_request(3, 0));
        verb = WORD_DEL; arg_len[1] = 1;
        void'(build_request(2, 0));
        verb = WORD_GET; arg_len[2] = 2;
        void'(build_request(3, 0));
        verb = WORD_SET;
        void'(build_request(2, 0));
        verb = WORD_GET; arg_len[0] = 4;
        void'(build_request(2, 0));
        verb = 24'h786567; arg_len[0] = 3;
        void'(build_request(2, 0));
        void'(build_request(0, 0));
        arg_len[0] = 0; arg_len[1] = 0; arg_len[2] = 2;
        void'(build_request(3, 0));
        void'(build_request(1, 0));
        verb = WORD_GET; arg_len[0] = 2; arg_len[1] = 1;
        void'(build_request(2, 0));
        flush_items();

        // errors, each followed by a new connection
        add_word(32'hFFFF_FFFF);
        add_noise(3);
        next_nc = 1'b1; add_word(32'd4097);
        next_nc = 1'b1; add_word(32'd0);
        next_nc = 1'b1; add_word(32'd3);
        next_nc = 1'b1; add_word(32'd8); add_word(32'd4097);
        next_nc = 1'b1; add_word(32'd8); add_word(32'd0); add_word(32'd0);
        next_nc = 1'b1; add_word(32'd4); add_word(32'd1);
        next_nc = 1'b1; add_word(32'd12); add_word(32'd2); add_word(32'd100);
        verb = WORD_GET; arg_len[0] = 3; arg_len[1] = 3;
        next_nc = 1'b1; void'(build_request(2, -1));
        next_nc = 1'b1; void'(build_request(2, 5));
        verb = WORD_SET; arg_len[1] = 2; arg_len[2] = 2;
        next_nc = 1'b1; void'(build_request(3, 0));
        set_nc(req_q.size() - 6);
        verb = WORD_DEL;
        next_nc = 1'b1; void'(build_request(2, 0));
        flush_items();

        // a long run of empty arguments
        for (i = 0; i < 60; i++)
            arg_len[i] = 0;
        next_nc = 1'b1;
        void'(build_request(60, 0));
        flush_items();

        // limit extremes
        drain_results();
        write_limit(13'd0);
        verb = WORD_GET; arg_len[0] = 3; arg_len[1] = 1;
        next_nc = 1'b1; void'(build_request(2, 0));
        next_nc = 1'b1; add_word(32'd0);
        flush_items();
        drain_results();
        write_limit(13'd8191);
        next_nc = 1'b1; add_word(32'd4097);
        next_nc = 1'b1; void'(build_request(2, 0));
        flush_items();
        drain_results();
        write_limit(13'd16);
        next_nc = 1'b1; add_word(32'd8); add_word(32'd17);
        next_nc = 1'b1; void'(build_request(2, 0));
        flush_items();

        // random requests under several limits
        tainted = 1'b1;
        for (p = 0; p < 4; p++) begin
            drain_results();
            case (p)
                0: write_limit(13'd8191);
                1: write_limit(13'($urandom_range(24, 200)));
                2: write_limit(13'd4096);
                default: write_limit(13'($urandom_range(0, 8191)));
            endcase
            target = bytes_sent + 150;
            while (bytes_sent < target)
                random_request();
        end

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/lprd_pkg.sv
hw/rtl/lprd_core.sv
hw/rtl/length_prefixed_request_deframer_unit.sv
tb/length_prefixed_request_deframer_checker.sv
tb/length_prefixed_request_deframer_unit_tb.sv
